// ----- hw/rtl/egcd_pkg.sv -----
package egcd_pkg;

    // Default operand width
    localparam int OPERAND_WIDTH_DEF = 32;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // take a new operand pair
        logic div_init;    // start a Euclid quotient: r0 / r1
        logic red_init;    // start the final reduction: |s0| mod b
        logic align_shift; // double the shifted divisor
        logic sub_step;    // one restoring subtract, one quotient bit
        logic update;      // rotate remainders and coefficients
        logic fix;         // fold a negative coefficient into [0,b)
        logic out_load;    // capture the result into the output register
    } egcd_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic r1_zero;   // Euclid loop finished
        logic inv_ok;    // modulus nonzero and gcd equals one
        logic can_shift; // divisor still fits twice under the remainder
        logic cnt_zero;  // last quotient bit in progress
    } egcd_sts_t;

endpackage

// ----- hw/rtl/egcd_in_if.sv -----
interface egcd_in_if #(
    parameter int OPERAND_WIDTH = 32
) ();
    logic                     valid;
    logic                     ready;
    logic [OPERAND_WIDTH-1:0] value_a;
    logic [OPERAND_WIDTH-1:0] modulus_b;

    modport source (output valid, output value_a, output modulus_b, input ready);
    modport sink   (input valid, input value_a, input modulus_b, output ready);
endinterface

// ----- hw/rtl/egcd_out_if.sv -----
interface egcd_out_if #(
    parameter int OPERAND_WIDTH = 32
) ();
    logic                        valid;
    logic                        ready;
    logic        [OPERAND_WIDTH-1:0] divisor;
    logic signed [OPERAND_WIDTH:0]   coef_a;
    logic signed [OPERAND_WIDTH:0]   coef_b;
    logic        [OPERAND_WIDTH-1:0] inverse_mod;
    logic                        inverse_valid;

    modport source (output valid, output divisor, output coef_a, output coef_b,
                    output inverse_mod, output inverse_valid, input ready);
    modport sink   (input valid, input divisor, input coef_a, input coef_b,
                    input inverse_mod, input inverse_valid, output ready);
endinterface

// ----- hw/rtl/egcd_datapath.sv -----
module egcd_datapath #(
    parameter int OPERAND_WIDTH = egcd_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                            clk,
    input  egcd_pkg::egcd_cmd_t             cmd,
    input  logic        [OPERAND_WIDTH-1:0] value_a,
    input  logic        [OPERAND_WIDTH-1:0] modulus_b,
    output egcd_pkg::egcd_sts_t             sts,
    output logic        [OPERAND_WIDTH-1:0] divisor,
    output logic signed [OPERAND_WIDTH:0]   coef_a,
    output logic signed [OPERAND_WIDTH:0]   coef_b,
    output logic        [OPERAND_WIDTH-1:0] inverse_mod,
    output logic                            inverse_valid
);
    import egcd_pkg::*;

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(OPERAND_WIDTH);

    // Euclid state
    logic [W-1:0] r0_reg, r1_reg, b_reg;
    logic [W:0]   s0_reg, s1_reg, t0_reg, t1_reg;

    // Shared divider state
    logic [W-1:0]     rem_reg;
    logic [W:0]       dsh_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W:0]       ps_reg, pt_reg;
    logic [W-1:0]     inv_reg;

    // Output register
    logic [W-1:0] divisor_reg, inverse_mod_reg;
    logic [W:0]   coef_a_reg, coef_b_reg;
    logic         inverse_valid_reg;

    logic [W+1:0] dsh_dbl;
    logic         can_shift;
    logic         sub_ok;
    logic [W-1:0] rem_diff;
    logic         s0_neg;
    logic [W:0]   s0_mag;
    logic         inv_ok;

    // Divider compares and coefficient magnitude
    always_comb
    begin
        dsh_dbl   = {dsh_reg, 1'b0};
        can_shift = dsh_dbl <= {2'b00, rem_reg};
        sub_ok    = {1'b0, rem_reg} >= dsh_reg;
        rem_diff  = rem_reg - dsh_reg[W-1:0];
        s0_neg    = s0_reg[W];
        s0_mag    = s0_neg ? (~s0_reg + (W+1)'(1)) : s0_reg;
        inv_ok    = (b_reg != '0) && (r0_reg == W'(1));
    end

    assign sts.r1_zero   = (r1_reg == '0);
    assign sts.inv_ok    = inv_ok;
    assign sts.can_shift = can_shift;
    assign sts.cnt_zero  = (cnt_reg == '0);

    // Datapath registers, one command per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            r0_reg <= value_a;
            r1_reg <= modulus_b;
            b_reg  <= modulus_b;
            s0_reg <= (W+1)'(1);
            s1_reg <= '0;
            t0_reg <= '0;
            t1_reg <= (W+1)'(1);
        end
        else if (cmd.div_init)
        begin
            rem_reg <= r0_reg;
            dsh_reg <= {1'b0, r1_reg};
            cnt_reg <= '0;
            ps_reg  <= '0;
            pt_reg  <= '0;
        end
        else if (cmd.red_init)
        begin
            rem_reg <= s0_mag[W-1:0];
            dsh_reg <= {1'b0, b_reg};
            cnt_reg <= '0;
        end
        else if (cmd.align_shift)
        begin
            dsh_reg <= dsh_dbl[W:0];
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        else if (cmd.sub_step)
        begin
            // Quotient bits come MSB first: accumulate q*s1 and q*t1
            if (sub_ok)
            begin
                rem_reg <= rem_diff;
            end
            ps_reg  <= {ps_reg[W-1:0], 1'b0} + (sub_ok ? s1_reg : '0);
            pt_reg  <= {pt_reg[W-1:0], 1'b0} + (sub_ok ? t1_reg : '0);
            dsh_reg <= {1'b0, dsh_reg[W:1]};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        else if (cmd.update)
        begin
            r0_reg <= r1_reg;
            r1_reg <= rem_reg;
            s0_reg <= s1_reg;
            s1_reg <= s0_reg - ps_reg;
            t0_reg <= t1_reg;
            t1_reg <= t0_reg - pt_reg;
        end
        else if (cmd.fix)
        begin
            inv_reg <= (s0_neg && (rem_reg != '0)) ? (b_reg - rem_reg) : rem_reg;
        end

        // Capture the result
        if (cmd.out_load)
        begin
            divisor_reg       <= r0_reg;
            coef_a_reg        <= s0_reg;
            coef_b_reg        <= t0_reg;
            inverse_mod_reg   <= inv_ok ? inv_reg : '0;
            inverse_valid_reg <= inv_ok;
        end
    end

    assign divisor       = divisor_reg;
    assign coef_a        = coef_a_reg;
    assign coef_b        = coef_b_reg;
    assign inverse_mod   = inverse_mod_reg;
    assign inverse_valid = inverse_valid_reg;

endmodule

// ----- hw/rtl/egcd_ctrl.sv -----
module egcd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  egcd_pkg::egcd_sts_t sts,
    output egcd_pkg::egcd_cmd_t cmd
);
    import egcd_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CHECK  = 7'b0000010,
        ST_ALIGN  = 7'b0000100,
        ST_SUB    = 7'b0001000,
        ST_UPDATE = 7'b0010000,
        ST_FIX    = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   red_reg, red_next;
    logic   out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        red_next   = red_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                priority if (!sts.r1_zero)
                begin
                    cmd.div_init = 1'b1;
                    red_next     = 1'b0;
                    state_next   = ST_ALIGN;
                end
                else if (sts.inv_ok)
                begin
                    cmd.red_init = 1'b1;
                    red_next     = 1'b1;
                    state_next   = ST_ALIGN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ALIGN:
            begin
                if (sts.can_shift)
                begin
                    cmd.align_shift = 1'b1;
                end
                else
                begin
                    state_next = ST_SUB;
                end
            end
            ST_SUB:
            begin
                cmd.sub_step = 1'b1;
                if (sts.cnt_zero)
                begin
                    state_next = red_reg ? ST_FIX : ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output beat valid: set on capture, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            red_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            red_reg       <= red_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- hw/rtl/extended_gcd_modular_inverse.sv -----
// Each Euclid step aligns the divisor by doubling, then takes the quotient bits by restoring
//   subtracts; when an inverse exists, the final reduction (|x| < b) needs a single subtract.
// One item at a time: the next beat is accepted in the cycle after capture, and the shared
//   divider sets how long each item takes.
// A finished result waits in the output register while the next beat is accepted.
// Reset (rst_n, asynchronous, active low) clears the controller and output valid.
module extended_gcd_modular_inverse #(
    parameter int OPERAND_WIDTH = egcd_pkg::OPERAND_WIDTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    egcd_in_if.sink   in_ch,
    egcd_out_if.source out_ch
);
    import egcd_pkg::*;

    egcd_cmd_t cmd;
    egcd_sts_t sts;

    egcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    egcd_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .cmd           (cmd),
        .value_a       (in_ch.value_a),
        .modulus_b     (in_ch.modulus_b),
        .sts           (sts),
        .divisor       (out_ch.divisor),
        .coef_a        (out_ch.coef_a),
        .coef_b        (out_ch.coef_b),
        .inverse_mod   (out_ch.inverse_mod),
        .inverse_valid (out_ch.inverse_valid)
    );

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

// Operand width used throughout the bench
localparam int OPW = egcd_pkg::OPERAND_WIDTH_DEF;

typedef struct {
    logic        [OPW-1:0] divisor;
    logic signed [OPW:0]   coef_a;
    logic signed [OPW:0]   coef_b;
    logic        [OPW-1:0] inverse_mod;
    logic                  inverse_valid;
} bezout_t;

class egcd_scoreboard;
    bezout_t pending_results[$];
    int      mismatches;

    function new();
        mismatches = 0;
    endfunction

    // Iterative extended Euclid; coefficients wrap mod 2^64, true values fit
    function bezout_t solve_bezout(logic [OPW-1:0] a, logic [OPW-1:0] b);
        bezout_t            res;
        logic        [63:0] r0, r1, rn, q;
        logic signed [63:0] s0, s1, sn, t0, t1, tn, bl, rem;
        r0 = 64'(a);
        r1 = 64'(b);
        s0 = 1;
        s1 = 0;
        t0 = 0;
        t1 = 1;
        while (r1 != 0)
        begin
            q  = r0 / r1;
            rn = r0 - q * r1;
            sn = s0 - $signed(q) * s1;
            tn = t0 - $signed(q) * t1;
            r0 = r1;
            r1 = rn;
            s0 = s1;
            s1 = sn;
            t0 = t1;
            t1 = tn;
        end
        res.divisor       = r0[OPW-1:0];
        res.coef_a        = s0[OPW:0];
        res.coef_b        = t0[OPW:0];
        res.inverse_valid = (b != 0) && (r0 == 1);
        res.inverse_mod   = '0;
        // Fold the first coefficient into [0,b)
        if (res.inverse_valid)
        begin
            bl  = 64'(b);
            rem = s0 % bl;
            if (rem < 0)
                rem = rem + bl;
            res.inverse_mod = rem[OPW-1:0];
        end
        return res;
    endfunction

    function void note_operands(logic [OPW-1:0] a, logic [OPW-1:0] b);
        pending_results.push_back(solve_bezout(a, b));
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    task report(string what, logic [OPW:0] got, logic [OPW:0] want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    task check_result(bezout_t got);
        bezout_t want;
        if (pending_results.size() == 0)
        begin
            report("unexpected result beat", (OPW+1)'(got.divisor), '0);
            return;
        end
        want = pending_results.pop_front();
        if (got.divisor !== want.divisor)
            report("divisor", (OPW+1)'(got.divisor), (OPW+1)'(want.divisor));
        if (got.coef_a !== want.coef_a)
            report("coef_a", got.coef_a, want.coef_a);
        if (got.coef_b !== want.coef_b)
            report("coef_b", got.coef_b, want.coef_b);
        if (got.inverse_mod !== want.inverse_mod)
            report("inverse_mod", (OPW+1)'(got.inverse_mod), (OPW+1)'(want.inverse_mod));
        if (got.inverse_valid !== want.inverse_valid)
            report("inverse_valid", (OPW+1)'(got.inverse_valid),
                   (OPW+1)'(want.inverse_valid));
    endtask
endclass

module testbench;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 400;
    localparam int RANDOM_ITEMS = 400;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   quiet_cycles;

    egcd_scoreboard sb;

    egcd_in_if  #(.OPERAND_WIDTH(OPW)) in_ch ();
    egcd_out_if #(.OPERAND_WIDTH(OPW)) out_ch ();

    extended_gcd_modular_inverse #(.OPERAND_WIDTH(OPW)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Directed pairs: zero operands, modulus one, extremes, longest Euclid chain
    logic [OPW-1:0] dir_a[$] = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd6,
                                 32'd2971215073, 32'd1836311903, 32'd12345, 32'd7,
                                 32'h8000_0000, 32'd2, 32'd3, 32'hAAAA_AAAA,
                                 32'h5555_5555, 32'd1, 32'hFFFF_FFFE, 32'd13};
    logic [OPW-1:0] dir_b[$] = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'hFFFF_FFFF,
                                 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd4,
                                 32'd1836311903, 32'd2971215073, 32'd0, 32'd13,
                                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                 32'h5555_5555, 32'hAAAA_AAAA, 32'd0, 32'hFFFF_FFFF, 32'd7};

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Return a value of random bit length
    function automatic logic [OPW-1:0] short_operand(int max_bits);
        logic [OPW-1:0] mask;
        mask = {OPW{1'b1}} >> (OPW - $urandom_range(1, max_bits));
        return $urandom & mask;
    endfunction

    task automatic pick_operands(output logic [OPW-1:0] a, output logic [OPW-1:0] b);
        case ($urandom_range(9))
            4:
            begin
                a = short_operand(12);
                b = short_operand(12);
            end
            5:
            begin
                a = short_operand(OPW);
                b = short_operand(OPW);
            end
            6:
            begin
                a = $urandom;
                b = $urandom_range(1);
            end
            7:
            begin
                b = short_operand(16);
                a = b * short_operand(16);
            end
            8:
            begin
                a = $urandom;
                b = $urandom_range(1) ? a + 1 : a - 1;
            end
            9:
            begin
                b = $urandom;
                a = $urandom_range(1) ? b : '0;
            end
            default:
            begin
                a = $urandom;
                b = $urandom;
            end
        endcase
    endtask

    // Present one beat at the falling edge and hold it until it is taken
    task automatic drive_pair(logic [OPW-1:0] a, logic [OPW-1:0] b);
        @(negedge clk);
        if (send_idle_pct > 0 && $urandom_range(7) == 0)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 300)) @(negedge clk);
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.value_a   = a;
        in_ch.modulus_b = b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_operands(a, b);
    endtask

    task automatic run_random(int count);
        logic [OPW-1:0] a, b;
        repeat (count)
        begin
            pick_operands(a, b);
            drive_pair(a, b);
        end
    endtask

    // Stall the result side at random, with an occasional long hold
    initial
    begin
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (recv_stall_pct > 0 && $urandom_range(63) == 0)
            begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(1, 400)) @(negedge clk);
            end
            out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every accepted result beat
    always @(posedge clk)
    begin
        bezout_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.divisor       = out_ch.divisor;
            got.coef_a        = out_ch.coef_a;
            got.coef_b        = out_ch.coef_b;
            got.inverse_mod   = out_ch.inverse_mod;
            got.inverse_valid = out_ch.inverse_valid;
            sb.check_result(got);
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        sb              = new();
        quiet_cycles    = 0;
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.value_a   = '0;
        in_ch.modulus_b = '0;
        send_idle_pct   = 25;
        recv_stall_pct  = 52;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed corners, then random beats under three idling mixes
        foreach (dir_a[i])
            drive_pair(dir_a[i], dir_b[i]);
        run_random(RANDOM_ITEMS);
        send_idle_pct  = 52;
        recv_stall_pct = 25;
        run_random(RANDOM_ITEMS);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(RANDOM_ITEMS);
        @(negedge clk);
        in_ch.valid = 1'b0;

        // Drain outstanding results, then let the block settle
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/egcd_pkg.sv
hw/rtl/egcd_in_if.sv
hw/rtl/egcd_out_if.sv
hw/rtl/egcd_datapath.sv
hw/rtl/egcd_ctrl.sv
hw/rtl/extended_gcd_modular_inverse.sv
test/testbench.sv
